/* hw/rtl/kvsd_pkg.sv */
// Package for the key/value stream deframer: word structs, byte class codes,
// magic sequence and prefix width decode. No dependencies.
package kvsd_pkg;

	localparam int unsigned MAGIC_LEN = 3;
	localparam int unsigned IDX_W     = $clog2(MAGIC_LEN);

	typedef enum logic [2:0] {
		CLS_MAGIC    = 3'd0,
		CLS_HEADER   = 3'd1,
		CLS_NAME_LEN = 3'd2,
		CLS_NAME_DAT = 3'd3,
		CLS_VAL_LEN  = 3'd4,
		CLS_VAL_DAT  = 3'd5,
		CLS_IGNORED  = 3'd6
	} byte_class_t;

	localparam logic [3:0] NAME_WIDTH_DFLT  = 4'd1;
	localparam logic [3:0] VALUE_WIDTH_DFLT = 4'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_package;
	} in_word_t;

	typedef struct packed {
		byte_class_t byte_class;
		logic [7:0]  data_out;
		logic [3:0]  name_width_bytes;
		logic [3:0]  value_width_bytes;
		logic [63:0] field_length;
		logic        length_done;
		logic        field_last;
		logic        pair_done;
		logic        magic_error;
	} out_word_t;

	// expected magic byte at a given position
	function automatic logic [7:0] magic_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h42;
			2'd1:    b = 8'h44;
			2'd2:    b = 8'h50;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// prefix width from the highest set bit of a nibble
	function automatic logic [3:0] nibble_width(input logic [3:0] nib, input logic [3:0] dflt);
		logic [3:0] w;
		if (nib[3])      w = 4'd8;
		else if (nib[2]) w = 4'd4;
		else if (nib[1]) w = 4'd2;
		else if (nib[0]) w = 4'd1;
		else             w = dflt;
		return w;
	endfunction

endpackage

/* hw/rtl/kv_package_stream_deframer_top.sv */
// Key/value package stream deframer, top level.
// Depends on kvsd_pkg (word structs, class codes, width decode).
//
// Usage:
//   Input channel item_valid/item_ready/item carries one stream byte per word,
//   with start_of_package marking the first magic byte of a package. Output
//   channel result_valid/result_ready/result carries one classification word
//   per input word, in order.
//   Path: an accepted word is registered in the input register, then in the
//   result register, which drives result until it is taken.
//   Throughput: one word per cycle while the receiver takes results. Each word
//   passes once through an input register, then the parse logic (a 64-bit
//   shift/accumulate, a 64-bit decrement and zero test) into the result
//   register, updating the parse state on the same edge.
//   Stall: when result_ready is low the result register holds and the input
//   register fills; item_ready drops only when both are full.
//   Reset: arst_n clears both stages; the parser waits for the first magic
//   byte with widths 1 (name) and 4 (value) and no error.
//   A magic mismatch sets magic_error, which holds and marks every later
//   byte as ignored until a word with start_of_package arrives.
module kv_package_stream_deframer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  kvsd_pkg::in_word_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output kvsd_pkg::out_word_t result
);
	import kvsd_pkg::*;

	typedef enum logic [2:0] {
		PH_MAGIC0   = 3'd0,
		PH_MAGIC1   = 3'd1,
		PH_MAGIC2   = 3'd2,
		PH_HEADER   = 3'd3,
		PH_NAME_LEN = 3'd4,
		PH_NAME_DAT = 3'd5,
		PH_VAL_LEN  = 3'd6,
		PH_VAL_DAT  = 3'd7
	} phase_t;

	// input stage
	logic     valid_s1;
	in_word_t word_s1;

	// parse state
	phase_t      phase_q;
	logic [2:0]  count_q;
	logic [63:0] acc_q;
	logic [63:0] remain_q;
	logic [3:0]  nsize_q;
	logic [3:0]  vsize_q;
	logic        err_q;

	// result stage
	logic      out_valid_q;
	out_word_t out_q;

	logic out_free;
	logic advance;

	assign out_free     = !out_valid_q || result_ready;
	assign advance      = valid_s1 && out_free;
	assign item_ready   = !valid_s1 || out_free;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// next state and result word
	phase_t      ph_n;
	logic [2:0]  cnt_n;
	logic [63:0] acc_n;
	logic [63:0] rem_n;
	logic [3:0]  ns_n;
	logic [3:0]  vs_n;
	logic        err_n;
	out_word_t   res;

	always_comb begin
		logic        is_val;
		logic [3:0]  w;
		logic [3:0]  cnt_inc;
		logic [63:0] flen;
		logic [63:0] rem_dec;
		logic [7:0]  b;

		b       = word_s1.data_byte;
		ph_n    = phase_q;
		cnt_n   = count_q;
		acc_n   = acc_q;
		rem_n   = remain_q;
		ns_n    = nsize_q;
		vs_n    = vsize_q;
		err_n   = err_q;
		if (word_s1.start_of_package) begin
			ph_n  = PH_MAGIC0;
			cnt_n = '0;
			acc_n = '0;
			rem_n = '0;
			ns_n  = NAME_WIDTH_DFLT;
			vs_n  = VALUE_WIDTH_DFLT;
			err_n = 1'b0;
		end

		res            = '0;
		res.byte_class = CLS_IGNORED;
		res.data_out   = b;

		is_val  = (ph_n == PH_VAL_LEN) || (ph_n == PH_VAL_DAT);
		w       = is_val ? vs_n : ns_n;
		cnt_inc = {1'b0, cnt_n} + 4'd1;
		flen    = {acc_n[55:0], b};
		rem_dec = (rem_n != '0) ? rem_n - 64'd1 : '0;

		if (!err_n) begin
			case (ph_n)
				PH_MAGIC0, PH_MAGIC1, PH_MAGIC2: begin
					res.byte_class = CLS_MAGIC;
					if (b != magic_byte(ph_n[IDX_W-1:0]))
						err_n = 1'b1;
					else
						ph_n = phase_t'(ph_n + 3'd1);
				end
				PH_HEADER: begin
					res.byte_class = CLS_HEADER;
					ns_n  = nibble_width(b[7:4], NAME_WIDTH_DFLT);
					vs_n  = nibble_width(b[3:0], VALUE_WIDTH_DFLT);
					cnt_n = '0;
					acc_n = '0;
					ph_n  = PH_NAME_LEN;
				end
				PH_NAME_LEN, PH_VAL_LEN: begin
					res.byte_class = is_val ? CLS_VAL_LEN : CLS_NAME_LEN;
					if (cnt_inc >= w) begin
						res.length_done  = 1'b1;
						res.field_length = flen;
						cnt_n = '0;
						acc_n = '0;
						if (flen == '0) begin
							res.field_last = 1'b1;
							res.pair_done  = is_val;
							ph_n = is_val ? PH_NAME_LEN : PH_VAL_LEN;
						end else begin
							rem_n = flen;
							ph_n  = is_val ? PH_VAL_DAT : PH_NAME_DAT;
						end
					end else begin
						acc_n = flen;
						cnt_n = cnt_inc[2:0];
					end
				end
				PH_NAME_DAT, PH_VAL_DAT: begin
					res.byte_class = is_val ? CLS_VAL_DAT : CLS_NAME_DAT;
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						res.field_last = 1'b1;
						res.pair_done  = is_val;
						cnt_n = '0;
						acc_n = '0;
						ph_n  = is_val ? PH_NAME_LEN : PH_VAL_LEN;
					end
				end
				default: begin
					ph_n = PH_MAGIC0;
				end
			endcase
		end

		res.name_width_bytes  = ns_n;
		res.value_width_bytes = vs_n;
		res.magic_error       = err_n;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			word_s1 <= item;
		end
	end

	// parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC0;
			count_q     <= '0;
			acc_q       <= '0;
			remain_q    <= '0;
			nsize_q     <= NAME_WIDTH_DFLT;
			vsize_q     <= VALUE_WIDTH_DFLT;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q  <= ph_n;
				count_q  <= cnt_n;
				acc_q    <= acc_n;
				remain_q <= rem_n;
				nsize_q  <= ns_n;
				vsize_q  <= vs_n;
				err_q    <= err_n;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	// a held result word must not change while the receiver stalls
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed under stall");

	a_len_class: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.length_done |->
			result.byte_class == CLS_NAME_LEN || result.byte_class == CLS_VAL_LEN)
		else $error("length_done outside a length prefix");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pair_done |-> result.field_last &&
			(result.byte_class == CLS_VAL_LEN || result.byte_class == CLS_VAL_DAT))
		else $error("pair_done outside the end of a value field");

	a_err_class: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.magic_error |->
			result.byte_class == CLS_MAGIC || result.byte_class == CLS_IGNORED)
		else $error("byte parsed while magic error is set");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && out_valid_q && !result_ready)
		else $error("input stalled with room in the pipeline");

endmodule

/* tb/tb.sv */
// Testbench for kv_package_stream_deframer_top: a directed table, then random packages,
// all checked word by word against table words or an in-bench deframer model.
// Depends on kvsd_pkg and the deframer RTL.
module tb;
	import kvsd_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam logic [23:0] MAGIC_SEQ   = 24'h424450;

	typedef enum logic [2:0] {
		PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_HEADER,
		PH_NAME_LEN, PH_NAME_DAT, PH_VAL_LEN, PH_VAL_DAT
	} phase_t;

	typedef struct {
		in_word_t  word;
		bit        typed;
		out_word_t known;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_word_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_word_t result;

	// deframer model state
	phase_t      phase;
	logic [2:0]  prefix_count;
	logic [63:0] len_acc;
	logic [63:0] data_left;
	logic [3:0]  name_w;
	logic [3:0]  value_w;
	logic        err_flag;

	out_word_t   expected_words[$];
	stim_row_t   directed_rows[$];
	out_word_t   oldest;
	int          fail_count = 0;
	int          words_counted = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_off_left = 0;

	kv_package_stream_deframer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [3:0] prefix_width(input logic [3:0] nib, input logic [3:0] dflt);
		if (nib[3]) return 4'd8;
		if (nib[2]) return 4'd4;
		if (nib[1]) return 4'd2;
		if (nib[0]) return 4'd1;
		return dflt;
	endfunction

	function automatic out_word_t typed_result(input byte_class_t c, input logic [7:0] d,
			input logic [3:0] nw, input logic [3:0] vw, input logic [63:0] len,
			input logic ld, input logic fl, input logic pd, input logic er);
		out_word_t r;
		r.byte_class = c;
		r.data_out = d;
		r.name_width_bytes = nw;
		r.value_width_bytes = vw;
		r.field_length = len;
		r.length_done = ld;
		r.field_last = fl;
		r.pair_done = pd;
		r.magic_error = er;
		return r;
	endfunction

	function automatic string word_text(input out_word_t r);
		return $sformatf("cls=%0d data=%h nw=%0d vw=%0d len=%h ld=%b fl=%b pd=%b err=%b",
			r.byte_class, r.data_out, r.name_width_bytes, r.value_width_bytes,
			r.field_length, r.length_done, r.field_last, r.pair_done, r.magic_error);
	endfunction

	task automatic restart_deframer();
		phase = PH_MAGIC0;
		prefix_count = '0;
		len_acc = '0;
		data_left = '0;
		name_w = NAME_WIDTH_DFLT;
		value_w = VALUE_WIDTH_DFLT;
		err_flag = 1'b0;
	endtask

	// classify one stream byte and advance the model
	task automatic deframe_byte(input in_word_t w, output out_word_t r);
		logic [7:0]  b;
		byte_class_t cls;
		logic [63:0] flen;
		logic        ld, fl, pd, is_val;
		int          wdt;
		b = w.data_byte;
		cls = CLS_IGNORED;
		flen = '0;
		ld = 1'b0;
		fl = 1'b0;
		pd = 1'b0;
		if (w.start_of_package)
			restart_deframer();
		if (!err_flag) begin
			case (phase)
				PH_MAGIC0, PH_MAGIC1, PH_MAGIC2: begin
					cls = CLS_MAGIC;
					if (b != MAGIC_SEQ[8 * (2 - int'(phase)) +: 8])
						err_flag = 1'b1;
					else
						phase = phase_t'(int'(phase) + 1);
				end
				PH_HEADER: begin
					cls = CLS_HEADER;
					name_w = prefix_width(b[7:4], NAME_WIDTH_DFLT);
					value_w = prefix_width(b[3:0], VALUE_WIDTH_DFLT);
					prefix_count = '0;
					len_acc = '0;
					phase = PH_NAME_LEN;
				end
				PH_NAME_LEN, PH_VAL_LEN: begin
					is_val = (phase == PH_VAL_LEN);
					wdt = is_val ? int'(value_w) : int'(name_w);
					cls = is_val ? CLS_VAL_LEN : CLS_NAME_LEN;
					len_acc = {len_acc[55:0], b};
					if (int'(prefix_count) + 1 >= wdt) begin
						ld = 1'b1;
						flen = len_acc;
						prefix_count = '0;
						len_acc = '0;
						if (flen == 0) begin
							// empty field: go straight to the next length
							fl = 1'b1;
							pd = is_val;
							phase = is_val ? PH_NAME_LEN : PH_VAL_LEN;
						end else begin
							data_left = flen;
							phase = is_val ? PH_VAL_DAT : PH_NAME_DAT;
						end
					end else begin
						prefix_count = prefix_count + 3'd1;
					end
				end
				default: begin
					is_val = (phase == PH_VAL_DAT);
					cls = is_val ? CLS_VAL_DAT : CLS_NAME_DAT;
					if (data_left != 0)
						data_left = data_left - 64'd1;
					if (data_left == 0) begin
						fl = 1'b1;
						pd = is_val;
						prefix_count = '0;
						len_acc = '0;
						phase = is_val ? PH_NAME_LEN : PH_VAL_LEN;
					end
				end
			endcase
		end
		r = typed_result(cls, b, name_w, value_w, flen, ld, fl, pd, err_flag);
	endtask

	// entered at a falling edge; returns at the falling edge after acceptance,
	// with valid still high
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t known);
		out_word_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		deframe_byte(w, r);
		expected_words.push_back(typed ? known : r);
		if (r.byte_class != CLS_IGNORED)
			words_counted++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] d, input logic sop);
		in_word_t w;
		w.data_byte = d;
		w.start_of_package = sop;
		send_word(w, 1'b0, '0);
	endtask

	task automatic send_magic();
		send_byte(MAGIC_SEQ[23:16], 1'b1);
		send_byte(MAGIC_SEQ[15:8], 1'b0);
		send_byte(MAGIC_SEQ[7:0], 1'b0);
	endtask

	task automatic send_length(input int wdt, input logic [63:0] len);
		for (int i = wdt - 1; i >= 0; i--)
			send_byte(8'(len >> (8 * i)), 1'b0);
	endtask

	task automatic well_formed_package();
		int          nfields, wdt;
		logic [63:0] len;
		send_magic();
		send_byte(8'($urandom_range(255)), 1'b0);
		nfields = $urandom_range(1, 10);
		for (int f = 0; f < nfields; f++) begin
			wdt = f[0] ? int'(value_w) : int'(name_w);
			if ($urandom_range(9) == 0) begin
				// huge length: up to three data bytes, then cut off by the next package
				len = {$urandom, $urandom};
				if (wdt < 8)
					len = len & ((64'd1 << (8 * wdt)) - 64'd1);
				send_length(wdt, len);
				repeat ($urandom_range(3))
					send_byte(8'($urandom_range(255)), 1'b0);
				return;
			end
			len = 64'($urandom_range(5));
			send_length(wdt, len);
			repeat (int'(len))
				send_byte(8'($urandom_range(255)), 1'b0);
		end
	endtask

	task automatic broken_package();
		case ($urandom_range(2))
			0: send_byte(8'($urandom_range(255)), 1'b1);
			1: begin
				send_byte(MAGIC_SEQ[23:16], 1'b1);
				send_byte(8'($urandom_range(255)), 1'b0);
			end
			default: begin
				send_byte(MAGIC_SEQ[23:16], 1'b1);
				send_byte(MAGIC_SEQ[15:8], 1'b0);
				send_byte(8'($urandom_range(255)), 1'b0);
			end
		endcase
		repeat ($urandom_range(4))
			send_byte(8'($urandom_range(255)), 1'($urandom_range(9) == 0));
	endtask

	task automatic pause_sender();
		item_valid <= 1'b0;
		wait (expected_words.size() == 0);
		@(negedge clk);
	endtask

	task automatic add_row(input logic [7:0] d, input logic sop, input bit typed,
			input out_word_t known);
		stim_row_t row;
		row.word.data_byte = d;
		row.word.start_of_package = sop;
		row.typed = typed;
		row.known = known;
		directed_rows.push_back(row);
	endtask

	// receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			result_ready <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_words.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result word: %s", word_text(result));
			end else begin
				oldest = expected_words.pop_front();
				if (result.byte_class !== oldest.byte_class
						|| result.data_out !== oldest.data_out
						|| result.name_width_bytes !== oldest.name_width_bytes
						|| result.value_width_bytes !== oldest.value_width_bytes
						|| result.field_length !== oldest.field_length
						|| result.length_done !== oldest.length_done
						|| result.field_last !== oldest.field_last
						|| result.pair_done !== oldest.pair_done
						|| result.magic_error !== oldest.magic_error) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch, expected: %s", word_text(oldest));
						$display("mismatch, actual:   %s", word_text(result));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int target;
		restart_deframer();

		// bad magic straight out of reset, then an ignored byte
		add_row(8'h00, 1'b0, 1'b1, typed_result(CLS_MAGIC, 8'h00, 1, 4, 0, 0, 0, 0, 1));
		add_row(8'hFF, 1'b0, 1'b1, typed_result(CLS_IGNORED, 8'hFF, 1, 4, 0, 0, 0, 0, 1));
		// restart, default widths, empty name and empty value
		add_row(8'h42, 1'b1, 1'b1, typed_result(CLS_MAGIC, 8'h42, 1, 4, 0, 0, 0, 0, 0));
		add_row(8'h44, 1'b0, 1'b0, '0);
		add_row(8'h50, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b1, typed_result(CLS_HEADER, 8'h00, 1, 4, 0, 0, 0, 0, 0));
		add_row(8'h00, 1'b0, 1'b1, typed_result(CLS_NAME_LEN, 8'h00, 1, 4, 0, 1, 1, 0, 0));
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b1, typed_result(CLS_VAL_LEN, 8'h00, 1, 4, 0, 1, 1, 1, 0));
		// widest prefixes and the largest length
		add_row(8'h42, 1'b1, 1'b0, '0);
		add_row(8'h44, 1'b0, 1'b0, '0);
		add_row(8'h50, 1'b0, 1'b0, '0);
		add_row(8'h88, 1'b0, 1'b1, typed_result(CLS_HEADER, 8'h88, 8, 8, 0, 0, 0, 0, 0));
		repeat (7)
			add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b1,
			typed_result(CLS_NAME_LEN, 8'hFF, 8, 8, '1, 1, 0, 0, 0));
		add_row(8'h55, 1'b0, 1'b0, '0);
		// restart mid-field, bad second magic byte
		add_row(8'h42, 1'b1, 1'b0, '0);
		add_row(8'h50, 1'b0, 1'b1, typed_result(CLS_MAGIC, 8'h50, 1, 4, 0, 0, 0, 0, 1));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 19;
		recv_idle_pct = 75;
		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].known);

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 19 : (p == 1) ? 75 : 0;
			recv_idle_pct = (p == 0) ? 75 : (p == 1) ? 19 : 0;
			target = words_counted + 370;
			while (words_counted < target) begin
				if ($urandom_range(99) < 85)
					well_formed_package();
				else
					broken_package();
			end
			if (p == 0) begin
				// long receiver stall so the block backs up into its input
				hold_off_left = 120;
				repeat (3)
					well_formed_package();
				pause_sender();
			end
		end

		pause_sender();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
